>>> hdl/icpid_pkg.sv
// icpid_pkg: shared types and constants for the four channel incremental pid block
// no dependencies; imported by four_channel_incremental_pid and its checker

package icpid_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned ProdW  = 33;
  localparam int unsigned IncW   = 35;
  localparam int unsigned AccW   = 40;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned DutyW  = 10;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET    = 2'd0,
    REG_GAIN_CUR  = 2'd1,
    REG_GAIN_LAST = 2'd2,
    REG_GAIN_PREV = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                     valid;
    logic                     in_range;
    logic [ChanW-1:0]         channel;
    logic signed [ProdW-1:0]  p_cur;
    logic signed [ProdW-1:0]  p_last;
    logic signed [ProdW-1:0]  p_prev;
  } prod_stage_t;

endpackage

>>> hdl/four_channel_incremental_pid.sv
// four_channel_incremental_pid: per-channel incremental pid speed controller
// depends on icpid_pkg; checked by icpid_checker (bound in its own file)

// One item per clock cycle is accepted when the result side keeps up; each item
// passes, after acceptance, through the input register, the multiply stage with the
// three gain products and the accumulate stage with saturation and duty clamp. An
// item on the same channel as the one before it sees that item's updated errors
// and drive, as errors are updated at the multiply stage and the drive at the
// accumulate stage. The channel travels in tuser, the count and duty in tdata.
// A stalled result holds the whole pipeline; the input register still fills.
// Registers are written by cfg_we_i and should change only while the block is idle.

module four_channel_incremental_pid
  import icpid_pkg::*;
#(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned OUTPUT_MAX = 900
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] measured_count
  input  logic [ChanW-1:0]    s_axis_tuser,   // [1:0] channel

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [9:0] duty, [15:10] zero
  output logic [ChanW-1:0]    m_axis_tuser,   // [1:0] out_channel

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [GainW-1:0]    cfg_data_i
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [AccW-1:0] AccMax  = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin  = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [AccW-1:0] DutyMax = AccW'(OUTPUT_MAX);

  // configuration
  logic [CountW-1:0]       target_q;
  logic signed [GainW-1:0] gain_cur_q, gain_last_q, gain_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      gain_cur_q  <= '0;
      gain_last_q <= '0;
      gain_prev_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TARGET:    target_q    <= cfg_data_i;
        REG_GAIN_CUR:  gain_cur_q  <= cfg_data_i;
        REG_GAIN_LAST: gain_last_q <= cfg_data_i;
        REG_GAIN_PREV: gain_prev_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic in_valid_q, in_valid_d;
  logic [ChanW-1:0]  in_chan_q;
  logic [CountW-1:0] in_count_q;
  logic              in_load;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en || !in_valid_q;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (en) begin
      in_valid_d = in_load;
    end else begin
      in_valid_d = in_valid_q || in_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_chan_q  <= s_axis_tuser;
      in_count_q <= s_axis_tdata;
    end
  end

  // multiply stage
  logic signed [ErrW-1:0] last_err_q  [CHANNELS];
  logic signed [ErrW-1:0] prior_err_q [CHANNELS];
  logic [IdxW-1:0]        in_idx;
  logic                   in_range;
  logic signed [ErrW-1:0] err;
  logic signed [ErrW-1:0] last_err_rd, prior_err_rd;
  prod_stage_t            prod_q, prod_d;

  assign in_idx       = IdxW'(in_chan_q);
  assign in_range     = 32'(in_chan_q) < CHANNELS;
  assign err          = $signed({1'b0, target_q}) - $signed({1'b0, in_count_q});
  assign last_err_rd  = last_err_q[in_idx];
  assign prior_err_rd = prior_err_q[in_idx];

  always_comb begin
    prod_d.valid    = in_valid_q;
    prod_d.in_range = in_range;
    prod_d.channel  = in_chan_q;
    prod_d.p_cur    = {{(ProdW-GainW){gain_cur_q[GainW-1]}}, gain_cur_q}
                    * {{(ProdW-ErrW){err[ErrW-1]}}, err};
    prod_d.p_last   = {{(ProdW-GainW){gain_last_q[GainW-1]}}, gain_last_q}
                    * {{(ProdW-ErrW){last_err_rd[ErrW-1]}}, last_err_rd};
    prod_d.p_prev   = {{(ProdW-GainW){gain_prev_q[GainW-1]}}, gain_prev_q}
                    * {{(ProdW-ErrW){prior_err_rd[ErrW-1]}}, prior_err_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_err_q[i]  <= '0;
        prior_err_q[i] <= '0;
      end
      prod_q <= '0;
    end else if (en) begin
      prod_q <= prod_d;
      if (in_valid_q && in_range) begin
        prior_err_q[in_idx] <= last_err_rd;
        last_err_q[in_idx]  <= err;
      end
    end
  end

  // accumulate stage
  logic signed [AccW-1:0] acc_q [CHANNELS];
  logic [IdxW-1:0]        acc_idx;
  logic signed [IncW-1:0] inc;
  logic signed [AccW:0]   acc_sum;
  logic signed [AccW-1:0] acc_new;
  logic [DutyW-1:0]       duty;
  logic                   out_valid_q;
  logic [ChanW-1:0]       out_chan_q;
  logic [DutyW-1:0]       out_duty_q;

  assign acc_idx = IdxW'(prod_q.channel);
  assign inc     = IncW'(prod_q.p_cur) - IncW'(prod_q.p_last) + IncW'(prod_q.p_prev);
  assign acc_sum = {acc_q[acc_idx][AccW-1], acc_q[acc_idx]}
                 + {{(AccW+1-IncW){inc[IncW-1]}}, inc};

  always_comb begin
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_new = acc_sum[AccW] ? AccMin : AccMax;
    end else begin
      acc_new = acc_sum[AccW-1:0];
    end
    if (!prod_q.in_range || acc_new < 0) begin
      duty = '0;
    end else if (acc_new > DutyMax) begin
      duty = DutyMax[DutyW-1:0];
    end else begin
      duty = acc_new[DutyW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        acc_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= prod_q.valid;
      if (prod_q.valid && prod_q.in_range) begin
        acc_q[acc_idx] <= acc_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_chan_q <= prod_q.channel;
      out_duty_q <= duty;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_chan_q;
  assign m_axis_tdata  = {{(16-DutyW){1'b0}}, out_duty_q};

endmodule

>>> hdl/icpid_checker.sv
// icpid_checker: port-level assertions for four_channel_incremental_pid
// depends on icpid_pkg; bound to the top level at the end of this file

module icpid_checker
  import icpid_pkg::*;
#(
  parameter int unsigned OUTPUT_MAX = 900
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [15:0]      m_axis_tdata,
  input logic [ChanW-1:0] m_axis_tuser
);

  localparam logic [15:0] DutyLimit = 16'(OUTPUT_MAX);

  // duty stays within the clamp range
  a_duty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= DutyLimit))
    else $error("duty above limit");

  // padding bits of the result are zero
  a_duty_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:DutyW] == '0))
    else $error("result padding not zero");

  // with no result waiting the block takes an item
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled item changed");

endmodule

bind four_channel_incremental_pid icpid_checker #(
  .OUTPUT_MAX(OUTPUT_MAX)
) u_icpid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
